/* hdl/substring_replace_stream_defines.svh */
// Assertion helpers for the checker file.
`ifndef SUBSTRING_REPLACE_STREAM_DEFINES_SVH
`define SUBSTRING_REPLACE_STREAM_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is low.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srs_pkg.sv */
package srs_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
  localparam int unsigned MAX_REPLACE_BYTES_DEF = 16;

  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_HI  = 3'd5;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // sequencer to output stage
  typedef struct packed {
    logic       emit;
    logic       done;
    logic [7:0] data;
    logic       present;
    logic       eos;
  } emit_req_t;

  // byte idx of a 16-byte vector, byte 0 in the low bits
  function automatic logic [7:0] byte_sel(input logic [127:0] v, input logic [3:0] idx);
    logic [6:0] base;
    base = {idx, 3'b000};
    return v[base +: 8];
  endfunction

endpackage

/* hdl/srs_cell.sv */
module srs_cell (
  input  logic                clk_i,
  input  srs_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          text_byte_i,
  input  logic [7:0]          next_i,
  input  logic [7:0]          pat_byte_i,
  input  logic                ok_i,
  output logic [7:0]          data_o,
  output logic                ok_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = text_byte_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // prefix match runs along the row
  assign ok_o   = ok_i & (data_q == pat_byte_i);

endmodule

/* hdl/srs_emit.sv */
module srs_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srs_pkg::emit_req_t req_i,
  output logic               rdy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         result_byte_o,
  output logic               result_present_o,
  output logic               run_last_o,
  output logic               string_end_o
);

  // one word parked until we know whether it closes the item
  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_data_q, pend_data_d;
  logic       pend_pres_q, pend_pres_d;
  logic       pend_eos_q, pend_eos_d;

  logic       out_v_q, out_v_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_pres_q, out_pres_d;
  logic       out_last_q, out_last_d;
  logic       out_eos_q, out_eos_d;

  logic out_free;
  logic out_load;

  assign out_free = !out_v_q || !out_stall_i;
  assign rdy_o    = !pend_v_q || out_free;

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_data_d = pend_data_q;
    pend_pres_d = pend_pres_q;
    pend_eos_d  = pend_eos_q;
    out_data_d  = out_data_q;
    out_pres_d  = out_pres_q;
    out_last_d  = out_last_q;
    out_eos_d   = out_eos_q;
    out_load    = 1'b0;

    if (req_i.emit && rdy_o) begin
      if (pend_v_q) begin
        out_load   = 1'b1;
        out_last_d = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_data_d = req_i.data;
      pend_pres_d = req_i.present;
      pend_eos_d  = req_i.eos;
    end else if (req_i.done && rdy_o && pend_v_q) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end

    if (out_load) begin
      out_data_d = pend_data_q;
      out_pres_d = pend_pres_q;
      out_eos_d  = pend_eos_q;
    end

    if (out_load) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_data_q <= pend_data_d;
    pend_pres_q <= pend_pres_d;
    pend_eos_q  <= pend_eos_d;
    out_data_q  <= out_data_d;
    out_pres_q  <= out_pres_d;
    out_last_q  <= out_last_d;
    out_eos_q   <= out_eos_d;
  end

  assign out_valid_o      = out_v_q;
  assign result_byte_o    = out_data_q;
  assign result_present_o = out_pres_q;
  assign run_last_o       = out_last_q;
  assign string_end_o     = out_eos_q;

endmodule

/* hdl/substring_replace_stream.sv */
// A byte passed straight through is parked in the output stage, then registered on the output.
// A word with a byte is scanned, then yields its shift-outs or replacement bytes; ending the
//   text adds a flush check and an end marker. An end-only word drains the window and sends the
//   end marker. Output stalls hold all of these up; no new word is taken until back in idle.
// Reset (rst_ni low, asynchronous): sequencer idle, window empty, configuration registers zero,
//   no output word pending.
module substring_replace_stream #(
  parameter int unsigned MAX_PATTERN_BYTES = srs_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned MAX_REPLACE_BYTES = srs_pkg::MAX_REPLACE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // text in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       text_byte_i,
  input  logic                             byte_present_i,
  input  logic                             text_end_i,
  // replaced text out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       result_byte_o,
  output logic                             result_present_o,
  output logic                             run_last_o,
  output logic                             string_end_o
);

  // One cell per window slot: at most MAX-1 held bytes plus the incoming one.
  localparam int unsigned NUM_CELLS = MAX_PATTERN_BYTES;
  localparam int unsigned FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned RL_W      = $clog2(MAX_REPLACE_BYTES + 1);
  localparam int unsigned CNT_W     = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,   // ready for a word
    ST_SCAN,   // check for full match, else shift out until a prefix remains
    ST_REPL,   // send replacement bytes
    ST_FLUSH,  // end of text: drain the window
    ST_MARK,   // send bare end marker
    ST_DONE    // close the item (flags run_last)
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [srs_pkg::LEN_W-1:0]      pat_len_q;
  logic [srs_pkg::CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [srs_pkg::LEN_W-1:0]      rep_len_q;
  logic [srs_pkg::CFG_DATA_W-1:0] rep_lo_q, rep_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      rep_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srs_pkg::CFG_PAT_LEN: pat_len_q <= cfg_wdata_i[srs_pkg::LEN_W-1:0];
        srs_pkg::CFG_PAT_LO:  pat_lo_q  <= cfg_wdata_i;
        srs_pkg::CFG_PAT_HI:  pat_hi_q  <= cfg_wdata_i;
        srs_pkg::CFG_REP_LEN: rep_len_q <= cfg_wdata_i[srs_pkg::LEN_W-1:0];
        srs_pkg::CFG_REP_LO:  rep_lo_q  <= cfg_wdata_i;
        srs_pkg::CFG_REP_HI:  rep_hi_q  <= cfg_wdata_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Oversized lengths saturate at the build maxima.
  logic [FILL_W-1:0] plen;
  logic [RL_W-1:0]   rlen;

  assign plen = (pat_len_q > srs_pkg::LEN_W'(MAX_PATTERN_BYTES)) ?
                FILL_W'(MAX_PATTERN_BYTES) : FILL_W'(pat_len_q);
  assign rlen = (rep_len_q > srs_pkg::LEN_W'(MAX_REPLACE_BYTES)) ?
                RL_W'(MAX_REPLACE_BYTES) : RL_W'(rep_len_q);

  // ---------------------------------------------------------------------------
  // Window: a row of cells, slot 0 oldest. Each cell compares its byte with
  // the pattern byte at its slot; ok_chain[k] is high when slots 0..k-1 all
  // match, so ok_chain[n] answers "first n held bytes are a pattern prefix".
  // ---------------------------------------------------------------------------
  logic [7:0]          cell_data [NUM_CELLS];
  srs_pkg::cell_ctrl_t cell_ctrl [NUM_CELLS];
  logic [NUM_CELLS:0]  ok_chain;
  logic                load_en;
  logic                shift_en;

  logic [FILL_W-1:0]   fill_q, fill_d;

  assign ok_chain[0] = 1'b1;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [7:0] next_byte;

    if (g == NUM_CELLS - 1) begin : g_tail
      assign next_byte = '0;
    end else begin : g_mid
      assign next_byte = cell_data[g+1];
    end

    assign cell_ctrl[g].load  = load_en && (fill_q == FILL_W'(g));
    assign cell_ctrl[g].shift = shift_en;

    srs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .text_byte_i (text_byte_i),
      .next_i      (next_byte),
      .pat_byte_i  (srs_pkg::byte_sel({pat_hi_q, pat_lo_q}, 4'(g))),
      .ok_i        (ok_chain[g]),
      .data_o      (cell_data[g]),
      .ok_o        (ok_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic               first_q, first_d;   // first look after appending the byte
  logic               end_q, end_d;       // item carried text_end
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  srs_pkg::emit_req_t req;
  logic               rdy;
  logic               accept;
  logic               hit;
  logic               hold_ok;
  logic               need_shift;
  logic               rep_last;
  state_e             after_st;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Full match only counts on the first look; one found later while shifting
  // (after a mid-text pattern change) goes out literally.
  assign hit        = first_q && (plen != '0) && (fill_q == plen) && ok_chain[plen];
  assign hold_ok    = (fill_q < plen) && ok_chain[fill_q];
  assign need_shift = (fill_q != '0) && !hold_ok;
  assign rep_last   = ((RL_W'(cnt_q) + RL_W'(1)) == rlen);
  assign after_st   = end_q ? ST_FLUSH : ST_DONE;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    first_d  = first_q;
    end_d    = end_q;
    cnt_d    = cnt_q;
    load_en  = 1'b0;
    shift_en = 1'b0;
    req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          end_d = text_end_i;
          if (byte_present_i) begin
            load_en = 1'b1;
            fill_d  = fill_q + FILL_W'(1);
            first_d = 1'b1;
            state_d = ST_SCAN;
          end else if (text_end_i) begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          fill_d  = '0;
          first_d = 1'b0;
          cnt_d   = '0;
          state_d = (rlen == '0) ? after_st : ST_REPL;
        end else if (need_shift) begin
          req.emit    = 1'b1;
          req.data    = cell_data[0];
          req.present = 1'b1;
          if (rdy) begin
            shift_en = 1'b1;
            fill_d   = fill_q - FILL_W'(1);
            first_d  = 1'b0;
          end
        end else begin
          state_d = after_st;
        end
      end

      ST_REPL: begin
        req.emit    = 1'b1;
        req.data    = srs_pkg::byte_sel({rep_hi_q, rep_lo_q}, 4'(cnt_q));
        req.present = 1'b1;
        if (rdy) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (rep_last) begin
            state_d = after_st;
          end
        end
      end

      ST_FLUSH: begin
        if (fill_q != '0) begin
          req.emit    = 1'b1;
          req.data    = cell_data[0];
          req.present = 1'b1;
          if (rdy) begin
            shift_en = 1'b1;
            fill_d   = fill_q - FILL_W'(1);
          end
        end else begin
          state_d = ST_MARK;
        end
      end

      ST_MARK: begin
        req.emit = 1'b1;
        req.eos  = 1'b1;
        if (rdy) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        req.done = 1'b1;
        if (rdy) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      first_q <= 1'b0;
      end_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      first_q <= first_d;
      end_q   <= end_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: parks one word until its run_last is known, then the
  // output register separates us from the downstream stall.
  // ---------------------------------------------------------------------------
  srs_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rdy_o            (rdy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_byte_o    (result_byte_o),
    .result_present_o (result_present_o),
    .run_last_o       (run_last_o),
    .string_end_o     (string_end_o)
  );

endmodule

/* hdl/srs_checker.sv */
`include "substring_replace_stream_defines.svh"

module srs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       byte_present_i,
  input logic       text_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] result_byte_o,
  input logic       result_present_o,
  input logic       run_last_o,
  input logic       string_end_o
);

  `SRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_byte_o) && $stable(result_present_o) && $stable(run_last_o) && $stable(string_end_o), "stalled output word changed")

  `SRS_ASSERT_NOW(a_eos_form, out_valid_o && string_end_o, !result_present_o && run_last_o && (result_byte_o == 8'd0), "malformed end marker")

  `SRS_ASSERT_NOW(a_bare_is_eos, out_valid_o && !result_present_o, string_end_o, "bare word without end flag")

  `SRS_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o && (byte_present_i || text_end_i), in_stall_o, "input not stalled while word in work")

endmodule

bind substring_replace_stream srs_checker u_srs_checker (.*);
